@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FSPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fspr check failed");

// next-cycle implication, disabled during reset
`define FSPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fspr check failed");

`endif

@@ hw/rtl/fspr_pkg.sv @@
// types and constants for the fan speed pwm regulator
// no dependencies
`default_nettype none

package fspr_pkg;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_SET     = 2'd1,
        CMD_INC     = 2'd2,
        CMD_DEC     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DRIVE_CLOSED  = 2'd0,
        DRIVE_LIMITED = 2'd1,
        DRIVE_FULL    = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        REG_DUTY_MAX       = 3'd0,
        REG_DUTY_MIN       = 3'd1,
        REG_DEAD_BAND      = 3'd2,
        REG_FINE_BAND      = 3'd3,
        REG_FINE_STEP      = 3'd4,
        REG_ROUGH_STEP     = 3'd5,
        REG_TARGET_FLOOR   = 3'd6,
        REG_TARGET_CEILING = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] value_high;
        logic [7:0] value_low;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_value;
        logic [7:0] duty_level;
        logic       pwm_running;
        t_drive     drive_mode;
    } t_out_item;

    typedef struct packed {
        logic [7:0] duty_max;
        logic [7:0] duty_min;
        logic [7:0] dead_band;
        logic [7:0] fine_band;
        logic [7:0] fine_step;
        logic [7:0] rough_step;
        logic [7:0] target_floor;
        logic [7:0] target_ceiling;
    } t_cfg;

    localparam logic [7:0] DUTY_MAX_RST       = 8'd160;
    localparam logic [7:0] DUTY_MIN_RST       = 8'd2;
    localparam logic [7:0] DEAD_BAND_RST      = 8'd2;
    localparam logic [7:0] FINE_BAND_RST      = 8'd6;
    localparam logic [7:0] FINE_STEP_RST      = 8'd1;
    localparam logic [7:0] ROUGH_STEP_RST     = 8'd5;
    localparam logic [7:0] TARGET_FLOOR_RST   = 8'd20;
    localparam logic [7:0] TARGET_CEILING_RST = 8'd100;

    localparam logic [7:0] DUTY_REG_RST = 8'd160;
    localparam logic [7:0] BYTE_MAX     = 8'hFF;

endpackage

`default_nettype wire

@@ hw/rtl/fspr_cfg_regs.sv @@
// apb-style configuration register bank of the regulator
// depends on fspr_pkg
`default_nettype none

module fspr_cfg_regs
    import fspr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;
    logic [7:0] w_rd;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_max       <= DUTY_MAX_RST;
            r_cfg.duty_min       <= DUTY_MIN_RST;
            r_cfg.dead_band      <= DEAD_BAND_RST;
            r_cfg.fine_band      <= FINE_BAND_RST;
            r_cfg.fine_step      <= FINE_STEP_RST;
            r_cfg.rough_step     <= ROUGH_STEP_RST;
            r_cfg.target_floor   <= TARGET_FLOOR_RST;
            r_cfg.target_ceiling <= TARGET_CEILING_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DUTY_MAX:       r_cfg.duty_max       <= pwdata[7:0];
                REG_DUTY_MIN:       r_cfg.duty_min       <= pwdata[7:0];
                REG_DEAD_BAND:      r_cfg.dead_band      <= pwdata[7:0];
                REG_FINE_BAND:      r_cfg.fine_band      <= pwdata[7:0];
                REG_FINE_STEP:      r_cfg.fine_step      <= pwdata[7:0];
                REG_ROUGH_STEP:     r_cfg.rough_step     <= pwdata[7:0];
                REG_TARGET_FLOOR:   r_cfg.target_floor   <= pwdata[7:0];
                REG_TARGET_CEILING: r_cfg.target_ceiling <= pwdata[7:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DUTY_MAX:       w_rd = r_cfg.duty_max;
            REG_DUTY_MIN:       w_rd = r_cfg.duty_min;
            REG_DEAD_BAND:      w_rd = r_cfg.dead_band;
            REG_FINE_BAND:      w_rd = r_cfg.fine_band;
            REG_FINE_STEP:      w_rd = r_cfg.fine_step;
            REG_ROUGH_STEP:     w_rd = r_cfg.rough_step;
            REG_TARGET_FLOOR:   w_rd = r_cfg.target_floor;
            REG_TARGET_CEILING: w_rd = r_cfg.target_ceiling;
            default:            w_rd = 8'd0;
        endcase
        prdata = {24'd0, w_rd};
    end

endmodule

`default_nettype wire

@@ hw/rtl/fspr_core.sv @@
// regulator state and the single-pass update for one request
// depends on fspr_pkg
`default_nettype none

module fspr_core
    import fspr_pkg::*;
#(
    parameter int SKIP_SAMPLES = 3
)(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_out_item     o_result
);

    localparam logic [1:0] SKIP_LIM = 2'(SKIP_SAMPLES);

    logic [7:0] r_target, n_target;
    logic [7:0] r_duty, n_duty;
    t_drive     r_drive, n_drive;
    logic [1:0] r_skip, n_skip;

    logic [7:0] w_meas, w_err, w_step, w_set, w_reply;
    logic       w_below;
    logic [8:0] w_up;
    logic [7:0] w_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 8'd0;
            r_duty   <= DUTY_REG_RST;
            r_drive  <= DRIVE_CLOSED;
            r_skip   <= 2'd0;
        end else if (i_fire) begin
            r_target <= n_target;
            r_duty   <= n_duty;
            r_drive  <= n_drive;
            r_skip   <= n_skip;
        end
    end

    // rounding to the high byte, saturating at full scale
    assign w_meas = (i_item.value_low[7] && i_item.value_high != BYTE_MAX)
                    ? i_item.value_high + 8'd1 : i_item.value_high;

    assign w_below = w_meas < r_target;
    assign w_err   = w_below ? r_target - w_meas : w_meas - r_target;
    assign w_up    = {1'b0, r_duty} + {1'b0, w_step};
    assign w_down  = r_duty - w_step;
    assign w_set   = (i_item.value_high > i_cfg.target_ceiling)
                     ? i_cfg.target_ceiling : i_item.value_high;

    always_comb begin
        priority if (w_err <= i_cfg.dead_band) begin
            w_step = 8'd0;
        end else if (w_err <= i_cfg.fine_band) begin
            w_step = i_cfg.fine_step;
        end else begin
            w_step = i_cfg.rough_step;
        end
    end

    always_comb begin
        n_target = r_target;
        n_duty   = r_duty;
        n_drive  = r_drive;
        n_skip   = r_skip;
        w_reply  = 8'd0;
        unique case (i_item.command)
            CMD_MEASURE: begin
                w_reply = w_meas;
                if (r_target != 8'd0) begin
                    if (r_skip < SKIP_LIM) begin
                        n_skip = r_skip + 2'd1;
                    end else begin
                        if (!w_below) begin
                            n_drive = DRIVE_FULL;
                        end
                        if (w_step != 8'd0) begin
                            if (w_below) begin
                                n_duty = (w_up < {1'b0, i_cfg.duty_max})
                                         ? w_up[7:0] : i_cfg.duty_max;
                            end else if (r_duty > w_step && w_down > i_cfg.duty_min) begin
                                n_duty = w_down;
                            end else begin
                                n_duty = i_cfg.duty_min;
                            end
                        end
                    end
                end
            end
            CMD_SET: begin
                w_reply = r_target;
                if (w_set != r_target) begin
                    if (r_target == 8'd0) begin
                        // restart from off
                        n_duty  = i_cfg.duty_min;
                        n_skip  = 2'd0;
                        n_drive = DRIVE_LIMITED;
                    end else if (w_set == 8'd0) begin
                        n_drive = DRIVE_CLOSED;
                    end
                    n_target = w_set;
                end
            end
            CMD_INC: begin
                priority if (i_item.value_high == 8'd0) begin
                    w_reply = i_cfg.target_floor;
                end else if (i_item.value_high < i_cfg.target_ceiling) begin
                    w_reply = i_item.value_high + 8'd1;
                end else begin
                    w_reply = i_item.value_high;
                end
            end
            CMD_DEC: begin
                w_reply = (i_item.value_high > i_cfg.target_floor)
                          ? i_item.value_high - 8'd1 : 8'd0;
            end
            default: begin
                w_reply = 8'd0;
            end
        endcase
    end

    assign o_result.reply_value = w_reply;
    assign o_result.duty_level  = n_duty;
    assign o_result.pwm_running = n_target != 8'd0;
    assign o_result.drive_mode  = n_drive;

endmodule

`default_nettype wire

@@ hw/rtl/fan_speed_pwm_regulator_top.sv @@
// Fan speed PWM regulator. One result per request; a request sits in an input
// register, is evaluated against the held target, duty, drive and skip state
// in a single pass, and lands in the result register. One request is accepted
// every cycle while the result side keeps up; a stalled result holds one
// further request in the input register before stall is raised.
// Configuration is to be written by the user over the APB-style port only
// while no request is in flight; the block itself does not enforce this.
// Depends on fspr_pkg, fspr_cfg_regs, fspr_core, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fan_speed_pwm_regulator_top
    import fspr_pkg::*;
#(
    parameter int SKIP_SAMPLES = 3
)(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out, w_result;
    logic      r_out_valid;
    logic      w_fire, w_in_acc;

    // request moves to the result register when that register is free or emptying
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    fspr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fspr_core #(
        .SKIP_SAMPLES (SKIP_SAMPLES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_item;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `FSPR_ASSERT_NXT(a_held_req_kept, r_in_valid && !w_fire, r_in_valid)
    `FSPR_ASSERT_NXT(a_fire_gives_result, w_fire, r_out_valid)
    `FSPR_ASSERT_IMP(a_no_stall_when_empty, !r_in_valid, !o_in_stall)
    `FSPR_ASSERT_IMP(a_off_means_closed, o_out_valid && !o_out_item.pwm_running,
        o_out_item.drive_mode == DRIVE_CLOSED)

endmodule

`default_nettype wire
